### hw/rtl/crcb_pkg.sv
// Shared types and constants for the Catmull-Rom channel blend pipeline.
`default_nettype none

package crcb_pkg;

	// Blend kind carried with each word through the pipeline.
	typedef enum logic {
		KIND_LINEAR = 1'b0,
		KIND_CUBIC  = 1'b1
	} kind_t;

	// Guard bits added above component plus fraction width for the cubic datapath.
	localparam int CUBIC_GUARD_BITS = 5;

endpackage

`default_nettype wire

### hw/rtl/crcb_front.sv
// Front stages: weight saturation, cubic coefficients, cubic term product and linear blend.
`default_nettype none

module crcb_front #(
	parameter int N = 16,
	parameter int F = 16
) (
	input  logic                                           clk,
	input  logic                                           en,
	input  crcb_pkg::kind_t                                kind,
	input  logic [N-1:0]                                   point_0,
	input  logic [N-1:0]                                   point_1,
	input  logic [N-1:0]                                   point_2,
	input  logic [N-1:0]                                   point_3,
	input  logic [F:0]                                     weight,
	output crcb_pkg::kind_t                                kind_s2,
	output logic [F:0]                                     t_s2,
	output logic [N-1:0]                                   p1_s2,
	output logic signed [N:0]                              c1_s2,
	output logic signed [N+3:0]                            c2_s2,
	output logic signed [N+F+crcb_pkg::CUBIC_GUARD_BITS-1:0] m3_s2,
	output logic [N-1:0]                                   lin_s2
);
	import crcb_pkg::*;

	localparam int AW = N + F + CUBIC_GUARD_BITS;
	localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};
	localparam logic [N+F+1:0] LIN_HALF = (N+F+2)'(1) << (F - 1);

	logic [F:0]              t_sat;
	logic signed [N+3:0]     e0, e1, e2, e3;
	logic signed [N+3:0]     c1_full, c2_full, c3_full;
	logic [N+F:0]            lin_a, lin_b;

	kind_t                   kind_s1;
	logic [F:0]              t_s1;
	logic [N-1:0]            p1_s1;
	logic signed [N:0]       c1_s1;
	logic signed [N+3:0]     c2_s1;
	logic signed [N+2:0]     c3_s1;
	logic [N+F:0]            lin_a_s1, lin_b_s1;

	logic signed [AW-1:0]    m3;
	logic [N+F+1:0]          lin_sum;

	// A weight above one is saturated to one.
	assign t_sat = (weight[F] && (|weight[F-1:0])) ? T_ONE : weight;

	// Control values widened to signed for the coefficient sums.
	assign e0 = signed'((N+4)'(point_0));
	assign e1 = signed'((N+4)'(point_1));
	assign e2 = signed'((N+4)'(point_2));
	assign e3 = signed'((N+4)'(point_3));

	// Hermite coefficients in power form.
	assign c1_full = e2 - e0;
	assign c2_full = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
	assign c3_full = (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;

	// Linear blend partial products.
	assign lin_a = (N+F+1)'(point_0) * (N+F+1)'(T_ONE - t_sat);
	assign lin_b = (N+F+1)'(point_1) * (N+F+1)'(t_sat);

	// Stage 1 registers.
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1  <= kind;
			t_s1     <= t_sat;
			p1_s1    <= point_1;
			c1_s1    <= c1_full[N:0];
			c2_s1    <= c2_full;
			c3_s1    <= c3_full[N+2:0];
			lin_a_s1 <= lin_a;
			lin_b_s1 <= lin_b;
		end
	end

	// Cubic term times t, and the rounded linear result.
	assign m3      = AW'(c3_s1) * AW'($signed({1'b0, t_s1}));
	assign lin_sum = (N+F+2)'(lin_a_s1) + (N+F+2)'(lin_b_s1) + LIN_HALF;

	// Stage 2 registers.
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			t_s2    <= t_s1;
			p1_s2   <= p1_s1;
			c1_s2   <= c1_s1;
			c2_s2   <= c2_s1;
			m3_s2   <= m3;
			lin_s2  <= lin_sum[F+N-1:F];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/crcb_wmul.sv
// Signed multiply by the weight with round to nearest, halves away from zero.
`default_nettype none

module crcb_wmul #(
	parameter int AW = 37,
	parameter int F  = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic [F:0]           t,
	output logic signed [AW-1:0] q
);
	import crcb_pkg::*;

	localparam logic [2*F+1:0] RND_HALF = (2*F+2)'(1) << (F - 1);

	logic signed [AW-F-1:0] a_hi;
	logic [F-1:0]           a_lo;
	logic signed [AW+1:0]   hi_mul;
	logic [2*F:0]           lo_mul;
	logic [2*F+1:0]         lo_sum;
	logic signed [AW+1:0]   hi_s1;
	logic [2*F+1:0]         lo_s1;
	logic signed [AW+1:0]   q_full;

	// The word splits into a signed high part and an unsigned low fraction.
	// A negative word rounds with one less than half so that halves move away from zero.
	assign a_hi   = a[AW-1:F];
	assign a_lo   = a[F-1:0];
	assign hi_mul = (AW+2)'(a_hi) * (AW+2)'($signed({1'b0, t}));
	assign lo_mul = (2*F+1)'(a_lo) * (2*F+1)'(t);
	assign lo_sum = (2*F+2)'(lo_mul) + (a[AW-1] ? RND_HALF - (2*F+2)'(1) : RND_HALF);

	// Partial product registers.
	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1 <= hi_mul;
			lo_s1 <= lo_sum;
		end
	end

	// Recombine: high product plus the rounded carry of the low product.
	assign q_full = hi_s1 + $signed((AW+2)'(lo_s1[2*F+1:F]));
	assign q      = q_full[AW-1:0];

endmodule

`default_nettype wire

### hw/rtl/catmull_rom_channel_blend.sv
// Top level of the Catmull-Rom / linear channel blend pipeline.
// Each accepted word carries four control values, a weight t and a kind; the block returns one
// interpolated value per word, linear between point_0 and point_1 or the Catmull-Rom segment
// from point_1 to point_2 clamped to the component range. A word may be accepted every cycle
// while the pipeline is not held, and it passes through eight register stages in order:
// coefficients and linear products, the cubic term product, the inner Horner sum, the first
// weight multiply and its recombination, the second weight multiply and its recombination,
// and the final round and clamp.
// When the last stage holds a result under out_stall the whole pipeline holds and in_stall rises.
`default_nettype none

module catmull_rom_channel_blend #(
	parameter int COMPONENT_BITS   = 16,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [COMPONENT_BITS-1:0]   point_0,
	input  logic [COMPONENT_BITS-1:0]   point_1,
	input  logic [COMPONENT_BITS-1:0]   point_2,
	input  logic [COMPONENT_BITS-1:0]   point_3,
	input  logic [WEIGHT_FRAC_BITS:0]   weight,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [COMPONENT_BITS-1:0]   value
);
	import crcb_pkg::*;

	localparam int N    = COMPONENT_BITS;
	localparam int F    = WEIGHT_FRAC_BITS;
	localparam int AW   = N + F + CUBIC_GUARD_BITS;
	localparam int TOTW = AW + 1;
	localparam logic signed [TOTW-1:0] TOT_ROUND = TOTW'(1) << F;

	logic                  en;
	logic [8:1]            vld_s;

	kind_t                 kind_s2, kind_s3, kind_s4, kind_s5, kind_s6, kind_s7;
	logic [F:0]            t_s2, t_s3, t_s4, t_s5;
	logic [N-1:0]          p1_s2, p1_s3, p1_s4, p1_s5, p1_s6, p1_s7;
	logic signed [N:0]     c1_s2, c1_s3, c1_s4;
	logic signed [N+3:0]   c2_s2;
	logic signed [AW-1:0]  m3_s2;
	logic [N-1:0]          lin_s2, lin_s3, lin_s4, lin_s5, lin_s6, lin_s7;

	logic signed [AW-1:0]  b_s3, c_s5, d_s7;
	logic signed [AW-1:0]  q1, q2;
	logic [N-1:0]          value_s8;

	logic signed [TOTW-1:0] tot;
	logic [TOTW-F-2:0]      tot_shift;
	logic [N-1:0]           cubic_val;

	// The pipeline advances unless a finished word waits at the output.
	assign en       = !(vld_s[8] && out_stall);
	assign in_stall = !en;

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[7:1], in_valid};
		end
	end

	// Stages 1 and 2: coefficients, cubic term and linear result.
	crcb_front #(
		.N (N),
		.F (F)
	) u_front (
		.clk     (clk),
		.en      (en),
		.kind    (kind_t'(kind)),
		.point_0 (point_0),
		.point_1 (point_1),
		.point_2 (point_2),
		.point_3 (point_3),
		.weight  (weight),
		.kind_s2 (kind_s2),
		.t_s2    (t_s2),
		.p1_s2   (p1_s2),
		.c1_s2   (c1_s2),
		.c2_s2   (c2_s2),
		.m3_s2   (m3_s2),
		.lin_s2  (lin_s2)
	);

	// Stage 3: inner Horner term c2*W + c3*t.
	always_ff @(posedge clk) begin
		if (en) begin
			b_s3    <= (AW'(c2_s2) <<< F) + m3_s2;
			kind_s3 <= kind_s2;
			t_s3    <= t_s2;
			p1_s3   <= p1_s2;
			c1_s3   <= c1_s2;
			lin_s3  <= lin_s2;
		end
	end

	// Stage 4: first weight multiply.
	crcb_wmul #(
		.AW (AW),
		.F  (F)
	) u_wmul_b (
		.clk (clk),
		.en  (en),
		.a   (b_s3),
		.t   (t_s3),
		.q   (q1)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s4 <= kind_s3;
			t_s4    <= t_s3;
			p1_s4   <= p1_s3;
			c1_s4   <= c1_s3;
			lin_s4  <= lin_s3;
		end
	end

	// Stage 5: add the linear coefficient term.
	always_ff @(posedge clk) begin
		if (en) begin
			c_s5    <= q1 + (AW'(c1_s4) <<< F);
			kind_s5 <= kind_s4;
			t_s5    <= t_s4;
			p1_s5   <= p1_s4;
			lin_s5  <= lin_s4;
		end
	end

	// Stage 6: second weight multiply.
	crcb_wmul #(
		.AW (AW),
		.F  (F)
	) u_wmul_c (
		.clk (clk),
		.en  (en),
		.a   (c_s5),
		.t   (t_s5),
		.q   (q2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s6 <= kind_s5;
			p1_s6   <= p1_s5;
			lin_s6  <= lin_s5;
		end
	end

	// Stage 7: recombined cubic offset.
	always_ff @(posedge clk) begin
		if (en) begin
			d_s7    <= q2;
			kind_s7 <= kind_s6;
			p1_s7   <= p1_s6;
			lin_s7  <= lin_s6;
		end
	end

	// Final rounding and clamp of the cubic result; a negative total gives zero.
	assign tot       = (signed'(TOTW'(p1_s7)) <<< (F + 1)) + TOTW'(d_s7) + TOT_ROUND;
	assign tot_shift = tot[TOTW-1:F+1];

	always_comb begin
		if (tot[TOTW-1]) begin
			cubic_val = '0;
		end else if (|tot_shift[TOTW-F-2:N]) begin
			cubic_val = '1;
		end else begin
			cubic_val = tot_shift[N-1:0];
		end
	end

	// Stage 8: output register.
	always_ff @(posedge clk) begin
		if (en) begin
			value_s8 <= (kind_s7 == KIND_LINEAR) ? lin_s7 : cubic_val;
		end
	end

	assign out_valid = vld_s[8];
	assign value     = value_s8;

endmodule

`default_nettype wire

### bench/catmull_rom_channel_blend_tb.sv
// Self-checking testbench for the linear and Catmull-Rom channel blend pipeline.
module catmull_rom_channel_blend_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crcb_pkg::*;

	localparam int COMP_BITS = 16;
	localparam int FRAC_BITS = 16;
	localparam int CLK_PERIOD = 10;
	localparam longint WONE = longint'(1) << FRAC_BITS;
	localparam longint COMP_MAX = (longint'(1) << COMP_BITS) - 1;
	localparam int RANDOM_WORDS = 1800;
	localparam int HOLD_CYCLES = 80;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 20;

	// One blend request together with the pacing that applies to it.
	typedef struct {
		kind_t                 kind;
		logic [COMP_BITS-1:0]  p0;
		logic [COMP_BITS-1:0]  p1;
		logic [COMP_BITS-1:0]  p2;
		logic [COMP_BITS-1:0]  p3;
		logic [FRAC_BITS:0]    weight;
		int                    phase;
		bit                    wait_drained;
	} blend_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	kind_t                 kind = KIND_LINEAR;
	logic [COMP_BITS-1:0]  point_0 = '0;
	logic [COMP_BITS-1:0]  point_1 = '0;
	logic [COMP_BITS-1:0]  point_2 = '0;
	logic [COMP_BITS-1:0]  point_3 = '0;
	logic [FRAC_BITS:0]    weight = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [COMP_BITS-1:0]  value;

	blend_word_t           word_queue[$];
	logic [COMP_BITS-1:0]  expected_values[$];
	bit                    in_took = 1'b0;
	int                    words_sent = 0;
	int                    results_seen = 0;
	int                    mismatch_count = 0;
	int                    rail_results = 0;
	int                    linear_words = 0;
	int                    cubic_words = 0;
	int                    saturated_words = 0;
	int                    total_words = 0;
	int                    phase_b_start = 1 << 30;
	int                    phase_c_start = 1 << 30;
	int                    hold_at = 1 << 30;
	int                    hold_left = 0;
	bit                    hold_done = 1'b0;
	int                    quiet_cycles = 0;

	catmull_rom_channel_blend #(
		.COMPONENT_BITS  (COMP_BITS),
		.WEIGHT_FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.point_0  (point_0),
		.point_1  (point_1),
		.point_2  (point_2),
		.point_3  (point_3),
		.weight   (weight),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value    (value)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Scale a signed quantity by t, rounding to nearest with halves away from zero.
	function automatic longint scale_by_weight(longint a, longint t);
		bit neg;
		longint mag, hi, lo, q;
		neg = a < 0;
		mag = neg ? -a : a;
		hi = mag >>> FRAC_BITS;
		lo = mag & (WONE - 1);
		q = hi * t + ((lo * t + WONE / 2) >>> FRAC_BITS);
		return neg ? -q : q;
	endfunction

	// Expected channel value for one word, linear or Catmull-Rom.
	function automatic logic [COMP_BITS-1:0] blend_value(kind_t k,
			logic [COMP_BITS-1:0] a0, logic [COMP_BITS-1:0] a1,
			logic [COMP_BITS-1:0] a2, logic [COMP_BITS-1:0] a3,
			logic [FRAC_BITS:0] w);
		longint q0, q1, q2, q3, t, c1, c2, c3, b, c, d, total, v;
		q0 = a0;
		q1 = a1;
		q2 = a2;
		q3 = a3;
		t = w;
		// A weight above one saturates to exactly one.
		if (t > WONE)
			t = WONE;
		if (k == KIND_LINEAR) begin
			v = (q0 * (WONE - t) + q1 * t + WONE / 2) >>> FRAC_BITS;
			return v[COMP_BITS-1:0];
		end
		// Horner form of the Hermite segment from point 1 to point 2.
		c1 = q2 - q0;
		c2 = 2 * q0 - 5 * q1 + 4 * q2 - q3;
		c3 = -q0 + 3 * q1 - 3 * q2 + q3;
		b = c2 * WONE + c3 * t;
		c = scale_by_weight(b, t) + c1 * WONE;
		d = scale_by_weight(c, t);
		total = q1 * 2 * WONE + d;
		// Undershoot clamps to zero and overshoot to all ones.
		if (total < 0)
			return '0;
		v = (total + WONE) >>> (FRAC_BITS + 1);
		if (v > COMP_MAX)
			v = COMP_MAX;
		return v[COMP_BITS-1:0];
	endfunction

	task automatic add_word(kind_t k, logic [COMP_BITS-1:0] a0, logic [COMP_BITS-1:0] a1,
			logic [COMP_BITS-1:0] a2, logic [COMP_BITS-1:0] a3,
			logic [FRAC_BITS:0] w, int phase, bit wait_drained);
		blend_word_t item;
		item.kind = k;
		item.p0 = a0;
		item.p1 = a1;
		item.p2 = a2;
		item.p3 = a3;
		item.weight = w;
		item.phase = phase;
		item.wait_drained = wait_drained;
		if (phase == 1 && phase_b_start == (1 << 30))
			phase_b_start = word_queue.size();
		if (phase == 2 && phase_c_start == (1 << 30))
			phase_c_start = word_queue.size();
		if (k == KIND_LINEAR)
			linear_words++;
		else
			cubic_words++;
		if (w > WONE)
			saturated_words++;
		word_queue.push_back(item);
	endtask

	// Driver: presents the next queued word at the falling edge once the previous one is taken.
	always @(negedge clk) begin
		bit offer;
		int idle_pct;
		offer = 1'b0;
		if (arst_n && (!in_valid || in_took)) begin
			if (word_queue.size() != 0) begin
				idle_pct = word_queue[0].phase == 0 ? 19 : (word_queue[0].phase == 1 ? 63 : 0);
				offer = !(word_queue[0].wait_drained && expected_values.size() != 0)
					&& ($urandom_range(99) >= idle_pct);
			end
			if (offer) begin
				kind <= word_queue[0].kind;
				point_0 <= word_queue[0].p0;
				point_1 <= word_queue[0].p1;
				point_2 <= word_queue[0].p2;
				point_3 <= word_queue[0].p3;
				weight <= word_queue[0].weight;
				void'(word_queue.pop_front());
			end
			in_valid <= offer;
		end
	end

	// Receiver: random stalls per phase, plus one long hold that backs up the pipeline.
	always @(negedge clk) begin
		int idle_pct;
		idle_pct = results_seen < phase_b_start ? 63 : (results_seen < phase_c_start ? 19 : 0);
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else if (!hold_done && results_seen >= hold_at) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= $urandom_range(99) < idle_pct;
		end
	end

	// Monitor: predicts each accepted word and checks each delivered result in order.
	always @(posedge clk) begin
		logic [COMP_BITS-1:0] want;
		if (arst_n) begin
			in_took <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				expected_values.push_back(blend_value(kind, point_0, point_1, point_2, point_3,
					weight));
				words_sent++;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (value == '0 || value == COMP_MAX[COMP_BITS-1:0])
					rail_results++;
				if (expected_values.size() == 0) begin
					$error("value: no word outstanding, actual %0d", value);
					mismatch_count++;
				end else begin
					want = expected_values.pop_front();
					if (value !== want) begin
						$error("value mismatch: expected %0d, actual %0d", want, value);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Watchdog: ends the run if neither side moves a word for too long.
	always @(posedge clk) begin
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles, %0d words outstanding",
				STALL_LIMIT, expected_values.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [COMP_BITS-1:0] pts[4];
		logic [FRAC_BITS:0]   w;
		int style, base, v, pick, phase;
		kind_t k;

		// Directed words: field extremes, saturation, rounding halves and clamping.
		add_word(KIND_LINEAR, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 17'd0, 0, 1'b0);
		add_word(KIND_LINEAR, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 17'd65536, 0, 1'b0);
		add_word(KIND_LINEAR, 16'h0000, 16'hFFFF, 16'h1234, 16'h4321, 17'd32768, 0, 1'b0);
		add_word(KIND_LINEAR, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 17'd1, 0, 1'b0);
		add_word(KIND_LINEAR, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 17'd32768, 0, 1'b0);
		add_word(KIND_LINEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'd65535, 0, 1'b0);
		add_word(KIND_LINEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 17'd40000, 0, 1'b0);
		add_word(KIND_LINEAR, 16'h1000, 16'hF000, 16'h0000, 16'h0000, 17'h1FFFF, 0, 1'b0);
		add_word(KIND_LINEAR, 16'hF000, 16'h1000, 16'h0000, 16'h0000, 17'd65537, 0, 1'b0);
		add_word(KIND_CUBIC, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 17'd0, 0, 1'b0);
		add_word(KIND_CUBIC, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 17'd65536, 0, 1'b0);
		add_word(KIND_CUBIC, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 17'h1FFFF, 0, 1'b0);
		add_word(KIND_CUBIC, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 17'd16384, 0, 1'b0);
		add_word(KIND_CUBIC, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 17'd32768, 0, 1'b0);
		add_word(KIND_CUBIC, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 17'd6000, 0, 1'b0);
		add_word(KIND_CUBIC, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'd32768, 0, 1'b0);
		add_word(KIND_CUBIC, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 17'd32768, 0, 1'b0);
		add_word(KIND_CUBIC, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 17'd1, 0, 1'b0);
		add_word(KIND_CUBIC, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 17'd65535, 0, 1'b0);

		// Random words in three pacing phases; each phase starts on a drained pipeline.
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			phase = i / (RANDOM_WORDS / 3);
			k = kind_t'($urandom_range(1));
			style = $urandom_range(9);
			base = $urandom_range(65535);
			for (int j = 0; j < 4; j++) begin
				if (style < 5) begin
					pts[j] = 16'($urandom_range(65535));
				end else if (style < 8) begin
					// Smooth curve: control values close to one another.
					v = base + int'($urandom_range(8192)) - 4096;
					if (v < 0)
						v = 0;
					if (v > 65535)
						v = 65535;
					pts[j] = v[COMP_BITS-1:0];
				end else begin
					pts[j] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				end
			end
			pick = $urandom_range(19);
			if (pick < 16) begin
				w = 17'($urandom_range(65536));
			end else if (pick < 18) begin
				case ($urandom_range(3))
					0: w = 17'd0;
					1: w = 17'd1;
					2: w = 17'd65535;
					default: w = 17'd65536;
				endcase
			end else begin
				w = 17'($urandom_range(131071));
			end
			add_word(k, pts[0], pts[1], pts[2], pts[3], w, phase,
				i % (RANDOM_WORDS / 3) == 0);
		end
		total_words = word_queue.size();
		hold_at = phase_c_start + 200;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (words_sent < total_words)
			@(negedge clk);
		while (expected_values.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Checked %0d results for %0d words: %0d linear, %0d cubic.",
			results_seen, total_words, linear_words, cubic_words);
		$display("Saturated weights: %0d; results at zero or full scale: %0d; mismatches: %0d.",
			saturated_words, rail_results, mismatch_count);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
hw/rtl/crcb_pkg.sv
hw/rtl/crcb_front.sv
hw/rtl/crcb_wmul.sv
hw/rtl/catmull_rom_channel_blend.sv
bench/catmull_rom_channel_blend_tb.sv
